// ----- src/wsbp_pkg.sv -----
// Package for the word segmentation best-path block.
// Holds field widths, kind codes, controller states, control/status structs and norm_kind.
// No dependencies.
package wsbp_pkg;

    localparam int MAX_LINE_DEF = 64;
    localparam int POS_W        = 6;
    localparam int KIND_W       = 2;

    localparam logic [KIND_W-1:0] KIND_WU   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DICT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNK  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TR_CHK,
        ST_TR_WAIT,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_POP_TBL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic cand_rd;     // item accepted: latch fields, read predecessor entry
        logic eval;        // compare candidate, update best, commit
        logic trace_init;  // start backtrace from committed position count
        logic trace_rd;    // read entry at i-1, push stop on stack
        logic trace_step;  // follow back-pointer
        logic pop_rd;      // pop stack
        logic pop_tbl;     // read entry of popped stop
        logic out_load;    // fill output register
        logic end_line;    // clear line state
    } cmd_t;

    typedef struct packed {
        logic line_end;
        logic i_zero;
        logic depth_zero;
        logic depth_full;
    } sts_t;

    function automatic logic [KIND_W-1:0] norm_kind(input logic [KIND_W-1:0] k);
        logic [KIND_W-1:0] r;
        r = KIND_UNK;
        if (k == KIND_WU || k == KIND_DICT) begin
            r = k;
        end
        return r;
    endfunction

endpackage

// ----- src/wsbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/wsbp_ctrl.sv -----
// Controller state machine for the segmentation block.
// Depends on wsbp_pkg (state_t, cmd_t, sts_t).
module wsbp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wsbp_pkg::sts_t   sts,
    output wsbp_pkg::cmd_t   cmd
);

    wsbp_pkg::state_t state_reg;
    wsbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            wsbp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cand_rd = 1'b1;
                    state_next  = wsbp_pkg::ST_EVAL;
                end
            end
            wsbp_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.line_end)
                begin
                    cmd.trace_init = 1'b1;
                    state_next     = wsbp_pkg::ST_TR_CHK;
                end
                else
                begin
                    state_next = wsbp_pkg::ST_IDLE;
                end
            end
            wsbp_pkg::ST_TR_CHK:
            begin
                if (sts.i_zero || sts.depth_full)
                begin
                    if (sts.depth_zero)
                    begin
                        cmd.end_line = 1'b1;
                        state_next   = wsbp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = wsbp_pkg::ST_POP_RD;
                    end
                end
                else
                begin
                    cmd.trace_rd = 1'b1;
                    state_next   = wsbp_pkg::ST_TR_WAIT;
                end
            end
            wsbp_pkg::ST_TR_WAIT:
            begin
                cmd.trace_step = 1'b1;
                state_next     = wsbp_pkg::ST_TR_CHK;
            end
            wsbp_pkg::ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = wsbp_pkg::ST_POP_WAIT;
            end
            wsbp_pkg::ST_POP_WAIT:
            begin
                cmd.pop_tbl = 1'b1;
                state_next  = wsbp_pkg::ST_POP_TBL;
            end
            wsbp_pkg::ST_POP_TBL:
            begin
                cmd.out_load = 1'b1;
                state_next   = wsbp_pkg::ST_OUT;
            end
            wsbp_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.depth_zero)
                    begin
                        cmd.end_line = 1'b1;
                        state_next   = wsbp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = wsbp_pkg::ST_POP_RD;
                    end
                end
            end
            default:
            begin
                state_next = wsbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/wsbp_dp.sv -----
// Datapath: cost table, segment stack, best-candidate compare and output register.
// Depends on wsbp_pkg and wsbp_ram.
module wsbp_dp #(
    parameter int MAX_LINE = wsbp_pkg::MAX_LINE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsbp_pkg::cmd_t                cmd,
    output wsbp_pkg::sts_t                sts,
    input  logic [wsbp_pkg::KIND_W-1:0]   cand_kind,
    input  logic [wsbp_pkg::POS_W-1:0]    cand_start,
    input  logic                          break_flag,
    input  logic                          last_in_position,
    input  logic                          last_in_line,
    output logic [wsbp_pkg::POS_W-1:0]    seg_start,
    output logic [wsbp_pkg::POS_W-1:0]    seg_stop,
    output logic [wsbp_pkg::KIND_W-1:0]   seg_kind,
    output logic                          last_segment,
    output logic                          overflow
);

    localparam int CNTW  = $clog2(MAX_LINE + 1);
    localparam int PW    = $clog2(MAX_LINE);
    localparam int XW    = (CNTW > wsbp_pkg::POS_W) ? CNTW : wsbp_pkg::POS_W;
    localparam int KW    = wsbp_pkg::KIND_W;
    localparam int COSTW = 4 * CNTW;
    localparam int EW    = COSTW + PW + KW;

    // Entry layout: {brk, unk, wu, dict, start, kind}
    logic [CNTW-1:0] pos_reg;
    logic            have_best_reg;
    logic            ovf_reg;
    logic [EW-1:0]   best_reg;
    logic [CNTW-1:0] i_reg;
    logic [CNTW-1:0] depth_reg;

    logic [KW-1:0]   kind_reg;
    logic [PW-1:0]   start_reg;
    logic            zero_pred_reg;
    logic            skip_reg;
    logic            brk_reg;
    logic            commit_reg;
    logic            line_end_reg;
    logic [PW-1:0]   stop_reg;

    logic [EW-1:0]   tbl_rdata;
    logic [PW-1:0]   stk_rdata;

    // candidate fields at the port
    logic [KW-1:0]   kind_n;
    logic [XW-1:0]   start_x;
    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   start_c_x;
    logic [PW-1:0]   start_c;
    logic            full;

    always_comb
    begin
        kind_n    = wsbp_pkg::norm_kind(cand_kind);
        start_x   = XW'(cand_start);
        pos_x     = XW'(pos_reg);
        start_c_x = (kind_n == wsbp_pkg::KIND_UNK || start_x > pos_x) ? pos_x : start_x;
        start_c   = start_c_x[PW-1:0];
        full      = (pos_reg == CNTW'(MAX_LINE));
    end

    // candidate cost
    logic [COSTW-1:0] pred_cost;
    logic [CNTW-1:0]  c_brk, c_unk, c_wu, c_dict;
    logic [EW-1:0]    cand;
    logic             take;
    logic [EW-1:0]    best_new;
    logic             do_commit;
    logic [CNTW-1:0]  pos_next;

    always_comb
    begin
        pred_cost = zero_pred_reg ? '0 : tbl_rdata[EW-1 -: COSTW];
        c_brk  = pred_cost[4*CNTW-1 -: CNTW] + CNTW'(brk_reg);
        c_unk  = pred_cost[3*CNTW-1 -: CNTW] + CNTW'(kind_reg == wsbp_pkg::KIND_UNK);
        c_wu   = pred_cost[2*CNTW-1 -: CNTW] + CNTW'(kind_reg == wsbp_pkg::KIND_WU);
        c_dict = pred_cost[CNTW-1:0]         + CNTW'(kind_reg == wsbp_pkg::KIND_DICT);
        cand   = {c_brk, c_unk, c_wu, c_dict, start_reg, kind_reg};
        // equal-width fields: concatenated compare is lexicographic
        take     = !have_best_reg || (cand[EW-1 -: COSTW] < best_reg[EW-1 -: COSTW]);
        best_new = take ? cand : best_reg;
        do_commit = cmd.eval && !skip_reg && commit_reg;
        pos_next  = do_commit ? pos_reg + 1'b1 : pos_reg;
    end

    logic [CNTW-1:0] i_m1;
    logic [CNTW-1:0] depth_m1;
    logic            tbl_rd_en;
    logic [PW-1:0]   tbl_rd_addr;

    always_comb
    begin
        i_m1        = i_reg - 1'b1;
        depth_m1    = depth_reg - 1'b1;
        tbl_rd_en   = cmd.cand_rd || cmd.trace_rd || cmd.pop_tbl;
        tbl_rd_addr = start_c - 1'b1;
        if (cmd.trace_rd)
        begin
            tbl_rd_addr = i_m1[PW-1:0];
        end
        else if (cmd.pop_tbl)
        begin
            tbl_rd_addr = stk_rdata;
        end
    end

    wsbp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LINE)
    ) u_cost_table (
        .clk     (clk),
        .wr_en   (do_commit),
        .wr_addr (pos_reg[PW-1:0]),
        .wr_data (best_new),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rdata)
    );

    wsbp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_LINE)
    ) u_seg_stack (
        .clk     (clk),
        .wr_en   (cmd.trace_rd),
        .wr_addr (depth_reg[PW-1:0]),
        .wr_data (i_m1[PW-1:0]),
        .rd_en   (cmd.pop_rd),
        .rd_addr (depth_m1[PW-1:0]),
        .rd_data (stk_rdata)
    );

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            have_best_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            best_reg      <= '0;
            i_reg         <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            if (cmd.cand_rd && full)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.eval && !skip_reg)
            begin
                best_reg      <= best_new;
                have_best_reg <= !commit_reg;
                pos_reg       <= pos_next;
            end
            if (cmd.trace_init)
            begin
                i_reg     <= pos_next;
                depth_reg <= '0;
            end
            if (cmd.trace_rd)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            if (cmd.trace_step)
            begin
                i_reg <= CNTW'(tbl_rdata[KW +: PW]);
            end
            if (cmd.pop_rd)
            begin
                depth_reg <= depth_m1;
            end
            if (cmd.end_line)
            begin
                pos_reg       <= '0;
                have_best_reg <= 1'b0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    // item and output payload
    logic [XW-1:0] seg_start_x;
    logic [XW-1:0] seg_stop_x;

    always_comb
    begin
        seg_start_x = XW'(tbl_rdata[KW +: PW]);
        seg_stop_x  = XW'(stop_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cand_rd)
        begin
            kind_reg      <= kind_n;
            start_reg     <= start_c;
            zero_pred_reg <= (start_c_x == '0);
            skip_reg      <= full;
            brk_reg       <= break_flag;
            commit_reg    <= last_in_position;
            line_end_reg  <= last_in_line;
        end
        if (cmd.pop_tbl)
        begin
            stop_reg <= stk_rdata;
        end
        if (cmd.out_load)
        begin
            seg_start    <= seg_start_x[wsbp_pkg::POS_W-1:0];
            seg_stop     <= seg_stop_x[wsbp_pkg::POS_W-1:0];
            seg_kind     <= tbl_rdata[KW-1:0];
            last_segment <= (depth_reg == '0);
            overflow     <= ovf_reg;
        end
    end

    always_comb
    begin
        sts.line_end   = line_end_reg;
        sts.i_zero     = (i_reg == '0);
        sts.depth_zero = (depth_reg == '0);
        sts.depth_full = (depth_reg == CNTW'(MAX_LINE));
    end

endmodule

// ----- src/word_segment_best_path.sv -----
// Best-path word segmentation: top level joining controller and datapath.
// Candidate item: accept (IDLE, predecessor-entry read) then compare (EVAL); no new item is taken in EVAL.
// Line end: backtrace loop (TR_CHK, TR_WAIT) per segment, then POP_RD, POP_WAIT, POP_TBL and OUT
// per segment, OUT waiting on out_ready; no item is taken until the last segment of the line is taken.
// Reset (rst_n, async low) clears position, best-candidate, overflow and controller state;
// cost table and segment stack RAMs are not cleared, only written entries are read.
module word_segment_best_path #(
    parameter int MAX_LINE = wsbp_pkg::MAX_LINE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // candidate channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wsbp_pkg::KIND_W-1:0]   cand_kind,
    input  logic [wsbp_pkg::POS_W-1:0]    cand_start,
    input  logic                          break_flag,
    input  logic                          last_in_position,
    input  logic                          last_in_line,
    // segment channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wsbp_pkg::POS_W-1:0]    seg_start,
    output logic [wsbp_pkg::POS_W-1:0]    seg_stop,
    output logic [wsbp_pkg::KIND_W-1:0]   seg_kind,
    output logic                          last_segment,
    output logic                          overflow
);

    wsbp_pkg::cmd_t cmd;
    wsbp_pkg::sts_t sts;

    // Sequencer: idle -> evaluate -> (line end) backtrace loop -> pop/emit loop.
    wsbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Cost table, segment stack, lexicographic compare and output register.
    wsbp_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cand_kind        (cand_kind),
        .cand_start       (cand_start),
        .break_flag       (break_flag),
        .last_in_position (last_in_position),
        .last_in_line     (last_in_line),
        .seg_start        (seg_start),
        .seg_stop         (seg_stop),
        .seg_kind         (seg_kind),
        .last_segment     (last_segment),
        .overflow         (overflow)
    );

    // Candidate intake and segment output never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a segment is pending");

    // Every accepted candidate is followed directly by evaluate, with intake closed, before the next one.
    a_eval_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.eval))
        else $error("candidate not followed by evaluate cycle");

    // After the final segment is taken the line state is cleared and intake resumes.
    a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_segment) |=> in_ready)
        else $error("block not idle after last segment");

endmodule

// ----- sim/tb_word_segment_best_path.sv -----
// Self-checking testbench for word_segment_best_path: candidate lines in, segments out.
// Predicts every segment from its own best-path model and checks each one in order.
// Depends on wsbp_pkg and word_segment_best_path (src/).
module tb_word_segment_best_path;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = wsbp_pkg::MAX_LINE_DEF;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 300;    // settle time after the last segment
    // cand_kind code outside the three kinds; the block treats it as unknown
    localparam logic [wsbp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // one candidate item as driven on the input channel
    typedef struct {
        logic [wsbp_pkg::KIND_W-1:0] kind;
        logic [wsbp_pkg::POS_W-1:0]  start;
        logic                        brk;
        logic                        commit;
        logic                        line_end;
    } cand_t;

    // one emitted segment
    typedef struct {
        logic [wsbp_pkg::POS_W-1:0]  start;
        logic [wsbp_pkg::POS_W-1:0]  stop;
        logic [wsbp_pkg::KIND_W-1:0] kind;
        logic                        last;
        logic                        ovf;
    } seg_t;

    // best path ending at a position: the four counts plus the back-pointer and kind
    typedef struct {
        logic [6:0]                  brk;
        logic [6:0]                  unk;
        logic [6:0]                  wu;
        logic [6:0]                  dict;
        logic [wsbp_pkg::POS_W-1:0]  start;
        logic [wsbp_pkg::KIND_W-1:0] kind;
    } path_cost_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [wsbp_pkg::KIND_W-1:0] cand_kind = '0;
    logic [wsbp_pkg::POS_W-1:0]  cand_start = '0;
    logic                        break_flag = 1'b0;
    logic                        last_in_position = 1'b0;
    logic                        last_in_line = 1'b0;

    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [wsbp_pkg::POS_W-1:0]  seg_start;
    logic [wsbp_pkg::POS_W-1:0]  seg_stop;
    logic [wsbp_pkg::KIND_W-1:0] seg_kind;
    logic                        last_segment;
    logic                        overflow;

    word_segment_best_path #(
        .MAX_LINE(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cand_kind(cand_kind),
        .cand_start(cand_start),
        .break_flag(break_flag),
        .last_in_position(last_in_position),
        .last_in_line(last_in_line),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .seg_start(seg_start),
        .seg_stop(seg_stop),
        .seg_kind(seg_kind),
        .last_segment(last_segment),
        .overflow(overflow)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    cand_t cand_queue[$];        // items waiting to be driven
    seg_t  expected_segs[$];     // segments predicted but not yet seen
    int    items_queued = 0;
    int    send_idle_pct = 0;    // chance per cycle that the sender holds off
    int    recv_stall_pct = 0;   // chance per cycle that out_ready is low
    int    mismatch_count = 0;
    int    quiet_cycles = 0;

    // Line state of the predictor. Reset is applied once, so the initial
    // values here match the block coming out of reset.
    path_cost_t path_tbl[LINE_DEPTH];
    path_cost_t best_path = '{default: '0};
    bit         best_valid = 1'b0;
    int         line_pos = 0;
    bit         line_ovf = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Lexicographic order: breaks, then unknowns, then word units, then dictionary.
    function automatic bit cost_lt(path_cost_t a, path_cost_t b);
        if (a.brk != b.brk)
        begin
            return a.brk < b.brk;
        end
        if (a.unk != b.unk)
        begin
            return a.unk < b.unk;
        end
        if (a.wu != b.wu)
        begin
            return a.wu < b.wu;
        end
        return a.dict < b.dict;
    endfunction

    // Folds one accepted candidate into the line state; on a line end, traces
    // the back-pointers and queues the segments in forward order.
    task automatic absorb_candidate(input cand_t c);
        path_cost_t cand;
        int pos;
        int st;
        int i;
        int stops[$];
        logic [wsbp_pkg::KIND_W-1:0] k;
        seg_t s;

        pos = line_pos;
        k = (c.kind == wsbp_pkg::KIND_WU || c.kind == wsbp_pkg::KIND_DICT) ?
            c.kind : wsbp_pkg::KIND_UNK;

        if (pos >= LINE_DEPTH)
        begin
            // table full: candidate and its commit are dropped
            line_ovf = 1'b1;
        end
        else
        begin
            // unknown words and starts past the position cover one character
            st = (k == wsbp_pkg::KIND_UNK || int'(c.start) > pos) ? pos : int'(c.start);
            if (st == 0)
            begin
                cand = '{default: '0};
            end
            else
            begin
                cand = path_tbl[st - 1];
            end
            cand.brk = cand.brk + 7'(c.brk);
            if (k == wsbp_pkg::KIND_UNK)
            begin
                cand.unk = cand.unk + 7'd1;
            end
            if (k == wsbp_pkg::KIND_WU)
            begin
                cand.wu = cand.wu + 7'd1;
            end
            if (k == wsbp_pkg::KIND_DICT)
            begin
                cand.dict = cand.dict + 7'd1;
            end
            cand.start = st[wsbp_pkg::POS_W-1:0];
            cand.kind = k;
            // strict compare: on a tie the earlier candidate stays
            if (!best_valid || cost_lt(cand, best_path))
            begin
                best_path = cand;
                best_valid = 1'b1;
            end
            if (c.commit)
            begin
                path_tbl[pos] = best_path;
                line_pos = pos + 1;
                best_valid = 1'b0;
            end
        end

        if (c.line_end)
        begin
            // an uncommitted best is simply dropped here
            i = line_pos;
            while (i > 0 && stops.size() < LINE_DEPTH)
            begin
                stops.push_front(i - 1);
                i = int'(path_tbl[i - 1].start);
            end
            foreach (stops[j])
            begin
                s.start = path_tbl[stops[j]].start;
                s.stop = stops[j][wsbp_pkg::POS_W-1:0];
                s.kind = path_tbl[stops[j]].kind;
                s.last = (j == stops.size() - 1);
                s.ovf = line_ovf;
                expected_segs.push_back(s);
            end
            line_pos = 0;
            best_valid = 1'b0;
            line_ovf = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one new item per handshake, random hold-off per cycle
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        cand_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cand_kind <= '0;
            cand_start <= '0;
            break_flag <= 1'b0;
            last_in_position <= 1'b0;
            last_in_line <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (cand_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                it = cand_queue.pop_front();
                in_valid <= 1'b1;
                cand_kind <= it.kind;
                cand_start <= it.start;
                break_flag <= it.brk;
                last_in_position <= it.commit;
                last_in_line <= it.line_end;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted candidate, check every segment
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        cand_t c;
        seg_t  want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (in_valid && in_ready)
            begin
                c.kind = cand_kind;
                c.start = cand_start;
                c.brk = break_flag;
                c.commit = last_in_position;
                c.line_end = last_in_line;
                absorb_candidate(c);
            end
            if (out_valid && out_ready)
            begin
                if (expected_segs.size() == 0)
                begin
                    $display("%0t ns: unexpected segment, expected none, actual start %0d stop %0d",
                             $time, seg_start, seg_stop);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_segs.pop_front();
                    check_field("seg_start", int'(want.start), int'(seg_start));
                    check_field("seg_stop", int'(want.stop), int'(seg_stop));
                    check_field("seg_kind", int'(want.kind), int'(seg_kind));
                    check_field("last_segment", int'(want.last), int'(last_segment));
                    check_field("overflow", int'(want.ovf), int'(overflow));
                end
            end
        end
    end

    // Watchdog: only a run that stops making progress gets here.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic [wsbp_pkg::KIND_W-1:0] kind, input int start,
                             input bit brk, input bit commit, input bit line_end);
        cand_t it;
        it.kind = kind;
        it.start = start[wsbp_pkg::POS_W-1:0];
        it.brk = brk;
        it.commit = commit;
        it.line_end = line_end;
        cand_queue.push_back(it);
        items_queued++;
    endtask

    // Well-formed line: per position some word candidates, then the unknown
    // one that commits. With open_end the line closes without a final commit.
    task automatic gen_line(input int npos, input int max_words, input bit open_end);
        int nw;
        int st;
        logic [wsbp_pkg::KIND_W-1:0] k;
        for (int p = 0; p < npos; p++)
        begin
            nw = $urandom_range(0, max_words);
            repeat (nw)
            begin
                k = $urandom_range(0, 1) ? wsbp_pkg::KIND_DICT : wsbp_pkg::KIND_WU;
                if ($urandom_range(0, 7) == 0)
                begin
                    st = $urandom_range(0, 63);
                end
                else
                begin
                    st = $urandom_range(0, (p > 63) ? 63 : p);
                end
                push_item(k, st, $urandom_range(0, 3) == 0, 1'b0, 1'b0);
            end
            if (p == npos - 1 && open_end)
            begin
                push_item(wsbp_pkg::KIND_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)), 1'b0, 1'b1);
            end
            else
            begin
                k = ($urandom_range(0, 5) == 0) ? KIND_SPARE : wsbp_pkg::KIND_UNK;
                push_item(k, $urandom_range(0, 63), $urandom_range(0, 3) == 0, 1'b1,
                          p == npos - 1);
            end
        end
    endtask

    // Mostly well-formed lines of short length, a few longer ones, some lines
    // left open and some bursts of arbitrary items closed by a line end.
    task automatic run_random(input int quota);
        int target;
        int r;
        int len;
        target = items_queued + quota;
        while (items_queued < target)
        begin
            r = $urandom_range(0, 9);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            if (r < 8)
            begin
                gen_line(len, 3, 1'b0);
            end
            else if (r == 8)
            begin
                gen_line(len, 2, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_item(wsbp_pkg::KIND_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
                push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b0, 1'b1);
            end
        end
    endtask

    // Holds the sender until every item is out and every segment is back.
    task automatic wait_drained();
        while (cand_queue.size() > 0 || in_valid || expected_segs.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines, no idling.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // empty line: a candidate but no commit, nothing comes out
        push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b0, 1'b1);
        // one character with a break, start field at its top value
        push_item(wsbp_pkg::KIND_UNK, 63, 1'b1, 1'b1, 1'b1);
        // tie at the last position: word unit from 2 and dictionary from 1
        // cost the same, the earlier one must stay
        push_item(wsbp_pkg::KIND_WU, 0, 1'b0, 1'b0, 1'b0);
        push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b1, 1'b0);
        push_item(wsbp_pkg::KIND_DICT, 0, 1'b0, 1'b0, 1'b0);
        push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b1, 1'b0);
        push_item(wsbp_pkg::KIND_WU, 2, 1'b0, 1'b0, 1'b0);
        push_item(wsbp_pkg::KIND_DICT, 1, 1'b0, 1'b0, 1'b0);
        push_item(KIND_SPARE, 63, 1'b1, 1'b1, 1'b1);
        // starts past the position, then a line end without a commit
        push_item(wsbp_pkg::KIND_DICT, 63, 1'b1, 1'b0, 1'b0);
        push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b1, 1'b0);
        push_item(wsbp_pkg::KIND_WU, 40, 1'b0, 1'b0, 1'b0);
        push_item(wsbp_pkg::KIND_UNK, 0, 1'b0, 1'b1, 1'b0);
        push_item(wsbp_pkg::KIND_WU, 0, 1'b0, 1'b0, 1'b1);
        wait_drained();

        // Phase 1: no idling.
        run_random(30);
        wait_drained();

        // Phase 2: sender idle half the time; a line filling the table exactly.
        send_idle_pct = 50;
        recv_stall_pct = 0;
        gen_line(LINE_DEPTH, 1, 1'b0);
        run_random(30);
        wait_drained();

        // Phase 3: receiver stalls half the time; a line running past the table.
        send_idle_pct = 0;
        recv_stall_pct = 50;
        gen_line(LINE_DEPTH + 6, 1, 1'b0);
        run_random(30);
        wait_drained();

        // Phase 4: both sides idle now and then.
        send_idle_pct = 12;
        recv_stall_pct = 12;
        run_random(30);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_segs.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
